### hdl/itp_pkg.sv
`default_nettype none

package itp_pkg;

  localparam int STACK_DEPTH_DEFAULT = 32;

  // operator codes kept on the stack
  localparam logic [2:0] CODE_OPEN  = 3'd0;
  localparam logic [2:0] CODE_PLUS  = 3'd1;
  localparam logic [2:0] CODE_MINUS = 3'd2;
  localparam logic [2:0] CODE_MUL   = 3'd3;
  localparam logic [2:0] CODE_DIV   = 3'd4;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_terminator;
    logic [1:0] error;
    logic       last;
  } out_t;

  function automatic logic [7:0] code_char(input logic [2:0] code);
    logic [7:0] c;
    unique case (code)
      CODE_OPEN:  c = CH_OPEN;
      CODE_PLUS:  c = CH_PLUS;
      CODE_MINUS: c = CH_MINUS;
      CODE_MUL:   c = CH_MUL;
      CODE_DIV:   c = CH_DIV;
      default:    c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] code_prio(input logic [2:0] code);
    logic [1:0] p;
    unique case (code)
      CODE_PLUS, CODE_MINUS: p = 2'd1;
      CODE_MUL, CODE_DIV:    p = 2'd2;
      default:               p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

### hdl/itp_stack.sv
`default_nettype none

module itp_stack #(
  parameter int DEPTH = itp_pkg::STACK_DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [2:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [2:0]    rdata
);

  logic [2:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/itp_seq.sv
`default_nettype none

module itp_seq #(
  parameter int DEPTH = itp_pkg::STACK_DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire itp_pkg::in_t in_data,
  input  wire logic         can_move,
  output logic              out_load,
  output itp_pkg::out_t     out_res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  localparam logic [1:0] KIND_END   = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_OP    = 2'd2;

  logic [1:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [1:0]    kind, kind_next;
  logic [2:0]    op_code, op_code_next;
  logic          fin_term, fin_term_next;
  logic [1:0]    fin_err, fin_err_next;
  logic          pend_valid, pend_valid_next;
  itp_pkg::out_t pend, pend_next;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [2:0]    wdata, rd_data;

  logic          step, gen, finish, pop;
  itp_pkg::out_t gen_res;
  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [2:0]    enc;
  logic [7:0]    ch;

  itp_stack #(.DEPTH(DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign cnt_m1   = cnt - CW'(1);
  assign cnt_m2   = cnt - CW'(2);
  assign in_ready = (state == ST_IDLE) && !pend_valid;
  assign ch       = in_data.ch;
  // a new result may push the held one out only if the output slot frees up
  assign step     = !pend_valid || can_move;

  always_comb begin
    priority if (ch == itp_pkg::CH_PLUS)  enc = itp_pkg::CODE_PLUS;
    else if (ch == itp_pkg::CH_MINUS)     enc = itp_pkg::CODE_MINUS;
    else if (ch == itp_pkg::CH_MUL)       enc = itp_pkg::CODE_MUL;
    else                                  enc = itp_pkg::CODE_DIV;
  end

  always_comb begin
    unique case (kind)
      KIND_END:   pop = 1'b1;
      KIND_CLOSE: pop = (rd_data != itp_pkg::CODE_OPEN);
      KIND_OP:    pop = (itp_pkg::code_prio(rd_data) >= itp_pkg::code_prio(op_code));
      default:    pop = 1'b0;
    endcase
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    kind_next       = kind;
    op_code_next    = op_code;
    fin_term_next   = fin_term;
    fin_err_next    = fin_err;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    out_load        = 1'b0;
    out_res         = pend;
    we              = 1'b0;
    waddr           = cnt[AW-1:0];
    wdata           = op_code;
    re              = 1'b0;
    raddr           = cnt_m1[AW-1:0];
    gen             = 1'b0;
    finish          = 1'b0;
    gen_res         = '0;

    unique case (state)
      ST_IDLE: begin
        if (pend_valid) begin
          // last result of the previous transaction
          if (can_move) begin
            out_load        = 1'b1;
            pend_valid_next = 1'b0;
          end
        end else if (in_valid) begin
          gen_res.last = 1'b1;
          if (in_data.cmd) begin
            kind_next = KIND_END;
            if (cnt == '0) begin
              gen                   = 1'b1;
              gen_res.is_terminator = 1'b1;
            end else begin
              re         = 1'b1;
              state_next = ST_EVAL;
            end
          end else if (ch == itp_pkg::CH_OPEN) begin
            if (cnt == CW'(DEPTH)) begin
              gen           = 1'b1;
              gen_res.error = itp_pkg::ERR_OVERFLOW;
            end else begin
              we       = 1'b1;
              wdata    = itp_pkg::CODE_OPEN;
              cnt_next = cnt + CW'(1);
            end
          end else if (ch == itp_pkg::CH_CLOSE) begin
            kind_next = KIND_CLOSE;
            if (cnt == '0) begin
              gen           = 1'b1;
              gen_res.error = itp_pkg::ERR_UNMATCHED;
            end else begin
              re         = 1'b1;
              state_next = ST_EVAL;
            end
          end else if (ch == itp_pkg::CH_PLUS || ch == itp_pkg::CH_MINUS ||
                       ch == itp_pkg::CH_MUL || ch == itp_pkg::CH_DIV) begin
            kind_next    = KIND_OP;
            op_code_next = enc;
            if (cnt == '0) begin
              we       = 1'b1;
              wdata    = enc;
              cnt_next = CW'(1);
            end else begin
              re         = 1'b1;
              state_next = ST_EVAL;
            end
          end else begin
            gen              = 1'b1;
            gen_res.out_char = ch;
          end
        end
      end

      ST_EVAL: begin
        if (step) begin
          if (pop) begin
            gen              = 1'b1;
            gen_res.out_char = itp_pkg::code_char(rd_data);
            cnt_next         = cnt_m1;
            if (cnt_m1 != '0) begin
              re    = 1'b1;
              raddr = cnt_m2[AW-1:0];
            end else begin
              unique case (kind)
                KIND_END: begin
                  fin_term_next = 1'b1;
                  fin_err_next  = itp_pkg::ERR_NONE;
                  state_next    = ST_FINAL;
                end
                KIND_CLOSE: begin
                  fin_term_next = 1'b0;
                  fin_err_next  = itp_pkg::ERR_UNMATCHED;
                  state_next    = ST_FINAL;
                end
                default: begin
                  // stack drained: the operator lands in the bottom slot
                  we           = 1'b1;
                  waddr        = '0;
                  cnt_next     = cnt;
                  gen_res.last = 1'b1;
                  state_next   = ST_IDLE;
                end
              endcase
            end
          end else if (kind == KIND_CLOSE) begin
            // matching '(' on top: drop it
            cnt_next   = cnt_m1;
            finish     = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_IDLE;
            if (cnt == CW'(DEPTH)) begin
              gen           = 1'b1;
              gen_res.error = itp_pkg::ERR_OVERFLOW;
              gen_res.last  = 1'b1;
            end else begin
              we       = 1'b1;
              cnt_next = cnt + CW'(1);
              finish   = 1'b1;
            end
          end
        end
      end

      ST_FINAL: begin
        if (step) begin
          gen                   = 1'b1;
          gen_res.is_terminator = fin_term;
          gen_res.error         = fin_err;
          gen_res.last          = 1'b1;
          state_next            = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (gen) begin
      if (pend_valid) begin
        out_load = 1'b1;
      end
      pend_valid_next = 1'b1;
      pend_next       = gen_res;
    end else if (finish) begin
      pend_next.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      pend_valid <= pend_valid_next;
    end
    kind     <= kind_next;
    op_code  <= op_code_next;
    fin_term <= fin_term_next;
    fin_err  <= fin_err_next;
    pend     <= pend_next;
  end

endmodule

`default_nettype wire

### hdl/infix_to_postfix_converter.sv
// Infix to postfix converter, operator-stack scheme.
// Input channel (in_valid/in_ready/in_data): one character or an end command
// per transaction. Output channel (out_valid/out_ready/out_data): one postfix
// character, terminator or error item per transaction; last marks the final
// result of an input transaction (a push or a bare '(' gives no result).
// The block works on one input at a time. A pass-through byte is written to
// the staging register on acceptance; a '(' or an operator pushed onto an
// empty stack needs no stack read, while an operator or ')' reads the top
// entry first. The stack memory has one registered read port, and the
// sequencer reads one entry per cycle unless a held result is stalled.
// Each result waits in a staging register until the next step shows whether
// it is the last, then moves to the output register.
// Reset clears the stack count and the control state; there is no clearing
// pass, stack entries are only read below the count.
// A stalled receiver holds the output register; the sequencer waits in place
// and in_ready stays low until the last result is in the output register.
`default_nettype none

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire itp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output itp_pkg::out_t      out_data
);

  logic          can_move;
  logic          out_load;
  itp_pkg::out_t out_res;

  assign can_move = !out_valid || out_ready;

  itp_seq #(.DEPTH(STACK_DEPTH)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .can_move (can_move),
    .out_load (out_load),
    .out_res  (out_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data <= out_res;
    end
  end

  // never overwrite a result the receiver has not taken
  assert property (@(posedge clk) disable iff (rst)
    out_load && out_valid |-> out_ready)
    else $error("output register overwritten while stalled");

  // nothing is pending while a new transaction may be taken
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_load)
    else $error("result moved while input ready");

  // a result held across an accept must be the last of its transaction
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid || $past(!out_valid) || out_data.last ||
      !$past(out_valid && !out_ready))
    else $error("non-final result outstanding at accept");

endmodule

`default_nettype wire
